/* rtl/cpfb_pkg.sv */
// Shared types, constants and CRC helpers for the CRC protected frame builder.
package cpfb_pkg;

    localparam int DATA_W      = 8;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMED_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_ID     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd2;

    localparam logic        FRAMED_MODE_RESET    = 1'b1;
    localparam logic [15:0] COMMAND_ID_RESET     = 16'h0310;
    localparam logic [15:0] PAYLOAD_LENGTH_RESET = 16'd300;

    localparam logic [7:0]  SOF_BYTE       = 8'hA5;
    localparam logic [7:0]  CRC8_INIT      = 8'hFF;
    localparam logic [7:0]  CRC8_POLY_REV  = 8'h8C;
    localparam logic [15:0] CRC16_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY_REV = 16'h8408;

    // Byte slots of one queued transaction, in emission order.
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_SOF     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SEQ     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HCRC    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CMD_LO  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CMD_HI  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CRC_LO  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CRC_HI  = 4'd9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic        framed_mode;
        logic [15:0] command_id;
        logic [15:0] payload_length;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              eop;
        logic              framed;
        logic              header;
        logic              tail;
    } item_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY_REV) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY_REV) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/cpfb_front.sv */
// Front end: configuration registers, input acceptance and frame position tracking.
module cpfb_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [cpfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cpfb_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    input  logic [cpfb_pkg::DATA_W-1:0]        payload_byte,
    input  logic                               end_of_packet,
    input  logic                               queue_full,
    output logic                               push,
    output cpfb_pkg::item_t                    push_item,
    output cpfb_pkg::cfg_t                     cfg
);

    cpfb_pkg::cfg_t cfg_reg;
    cpfb_pkg::cfg_t cfg_next;
    logic [15:0]    pos_reg;
    logic [15:0]    pos_next;
    logic [16:0]    pos_plus;
    logic [16:0]    limit;
    logic           tail;

    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                cpfb_pkg::CFG_FRAMED_MODE:    cfg_next.framed_mode    = cfg_data[0];
                cpfb_pkg::CFG_COMMAND_ID:     cfg_next.command_id     = cfg_data;
                cpfb_pkg::CFG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // A zero length stands for a full 65536-byte payload.
    assign pos_plus = {1'b0, pos_reg} + 17'd1;
    assign limit    = (cfg_reg.payload_length == 16'd0) ? 17'h10000
                                                        : {1'b0, cfg_reg.payload_length};
    assign tail     = (pos_plus >= limit);

    assign push = in_valid && !queue_full;

    always_comb
    begin
        push_item.data   = payload_byte;
        push_item.eop    = end_of_packet;
        push_item.framed = cfg_reg.framed_mode;
        push_item.header = cfg_reg.framed_mode && (pos_reg == 16'd0);
        push_item.tail   = cfg_reg.framed_mode && tail;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push && cfg_reg.framed_mode)
        begin
            pos_next = tail ? 16'd0 : pos_plus[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.framed_mode    <= cpfb_pkg::FRAMED_MODE_RESET;
            cfg_reg.command_id     <= cpfb_pkg::COMMAND_ID_RESET;
            cfg_reg.payload_length <= cpfb_pkg::PAYLOAD_LENGTH_RESET;
            pos_reg                <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            pos_reg <= pos_next;
        end
    end

endmodule

/* rtl/cpfb_queue.sv */
// Small register queue that decouples the front end from the byte emitter.
module cpfb_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpfb_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output cpfb_pkg::item_t head_item
);

    cpfb_pkg::item_t                  mem_reg [cpfb_pkg::QUEUE_DEPTH];
    logic [cpfb_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [cpfb_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [cpfb_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [cpfb_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [cpfb_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [cpfb_pkg::QUEUE_CNT_W-1:0] count_next;

    assign full       = (count_reg == cpfb_pkg::QUEUE_CNT_W'(cpfb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

endmodule

/* rtl/cpfb_back.sv */
// Back end: expands queued transactions into frame bytes and keeps both CRCs.
module cpfb_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cpfb_pkg::cfg_t              cfg,
    input  logic                        head_valid,
    input  cpfb_pkg::item_t             head_item,
    output logic                        pop,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [cpfb_pkg::DATA_W-1:0] out_byte,
    output logic                        frame_end
);

    logic [cpfb_pkg::PHASE_W-1:0] phase_reg;
    logic [cpfb_pkg::PHASE_W-1:0] phase_next;
    logic [cpfb_pkg::PHASE_W-1:0] eff_phase;
    logic [7:0]                   seq_reg;
    logic [7:0]                   seq_next;
    logic [7:0]                   crc8_reg;
    logic [7:0]                   crc8_next;
    logic [15:0]                  crc16_reg;
    logic [15:0]                  crc16_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [7:0]                   out_byte_reg;
    logic [7:0]                   out_byte_next;
    logic                         frame_end_reg;
    logic                         frame_end_next;
    logic                         fire;
    logic                         last;
    logic                         end_flag;
    logic [7:0]                   cur_byte;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

    // A transaction without a header starts directly at its payload byte.
    assign eff_phase = (phase_reg == cpfb_pkg::PH_SOF && !head_item.header)
                     ? cpfb_pkg::PH_PAYLOAD : phase_reg;

    assign fire = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (eff_phase)
            cpfb_pkg::PH_SOF:     cur_byte = cpfb_pkg::SOF_BYTE;
            cpfb_pkg::PH_LEN_LO:  cur_byte = cfg.payload_length[7:0];
            cpfb_pkg::PH_LEN_HI:  cur_byte = cfg.payload_length[15:8];
            cpfb_pkg::PH_SEQ:     cur_byte = seq_reg;
            cpfb_pkg::PH_HCRC:    cur_byte = crc8_reg;
            cpfb_pkg::PH_CMD_LO:  cur_byte = cfg.command_id[7:0];
            cpfb_pkg::PH_CMD_HI:  cur_byte = cfg.command_id[15:8];
            cpfb_pkg::PH_PAYLOAD: cur_byte = head_item.data;
            cpfb_pkg::PH_CRC_LO:  cur_byte = crc16_reg[7:0];
            cpfb_pkg::PH_CRC_HI:  cur_byte = crc16_reg[15:8];
            default:              cur_byte = head_item.data;
        endcase
    end

    assign last = ((eff_phase == cpfb_pkg::PH_PAYLOAD) && (!head_item.framed || !head_item.tail))
               || (eff_phase == cpfb_pkg::PH_CRC_HI);
    assign end_flag = head_item.framed ? (eff_phase == cpfb_pkg::PH_CRC_HI) : head_item.eop;
    assign pop = fire && last;

    always_comb
    begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        crc8_next      = crc8_reg;
        crc16_next     = crc16_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            frame_end_next = end_flag;
            phase_next     = last ? cpfb_pkg::PH_SOF : eff_phase + 1'b1;
            if (eff_phase <= cpfb_pkg::PH_SEQ)
            begin
                crc8_next = cpfb_pkg::crc8_byte(
                    (eff_phase == cpfb_pkg::PH_SOF) ? cpfb_pkg::CRC8_INIT : crc8_reg, cur_byte);
            end
            if (eff_phase == cpfb_pkg::PH_SEQ)
            begin
                seq_next = seq_reg + 8'd1;
            end
            // Pass-through bytes leave the frame CRC untouched.
            if (head_item.framed && eff_phase <= cpfb_pkg::PH_PAYLOAD)
            begin
                crc16_next = cpfb_pkg::crc16_byte(
                    (eff_phase == cpfb_pkg::PH_SOF) ? cpfb_pkg::CRC16_INIT : crc16_reg, cur_byte);
            end
            else if (eff_phase == cpfb_pkg::PH_CRC_HI)
            begin
                crc16_next = cpfb_pkg::CRC16_INIT;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cpfb_pkg::PH_SOF;
            seq_reg       <= 8'd0;
            crc8_reg      <= cpfb_pkg::CRC8_INIT;
            crc16_reg     <= cpfb_pkg::CRC16_INIT;
            out_valid_reg <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            crc8_reg      <= crc8_next;
            crc16_reg     <= crc16_next;
            out_valid_reg <= out_valid_next;
            frame_end_reg <= frame_end_next;
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= cpfb_pkg::PH_CRC_HI)
        else $error("byte slot out of range");

    a_passthrough_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head_item.framed) |-> (phase_reg == cpfb_pkg::PH_SOF))
        else $error("pass-through transaction found mid-frame");

    a_tail_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eff_phase == cpfb_pkg::PH_CRC_HI) |=> (out_valid && frame_end))
        else $error("CRC high byte not flagged as frame end");

    a_seq_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eff_phase == cpfb_pkg::PH_SEQ) |=> (seq_reg == $past(seq_reg) + 8'd1))
        else $error("sequence number did not advance after header");

endmodule

/* rtl/crc_protected_frame_builder_top.sv */
// Top level of the CRC protected frame builder: front end, queue and byte emitter.
// An accepted input byte is written into the queue and then registered in the byte emitter's output.
// Throughput: one output byte per cycle while the queue holds data and out_stall is low; a byte
// that opens a frame is preceded by seven prefix bytes, one that closes a frame by two CRC bytes.
// The byte emitter's single output register sets that figure; a four-entry queue buffers input.
// Reset: configuration returns to framed mode, command 0x0310, length 300; queue empties,
// sequence number and frame position clear, and the CRC-16 returns to all ones.
module crc_protected_frame_builder_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [cpfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cpfb_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         payload_byte,
    input  logic                               end_of_packet,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         out_byte,
    output logic                               frame_end
);

    cpfb_pkg::cfg_t  cfg;
    cpfb_pkg::item_t push_item;
    cpfb_pkg::item_t head_item;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            head_valid;

    assign in_stall = queue_full;

    cpfb_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .payload_byte  (payload_byte),
        .end_of_packet (end_of_packet),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item),
        .cfg           (cfg)
    );

    cpfb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    cpfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .frame_end  (frame_end)
    );

endmodule
